// ----- sv/sbus_frame_channel_decoder_core_macros.svh -----
// Assertion helpers shared by the decoder modules.
`ifndef SBUS_FRAME_CHANNEL_DECODER_CORE_MACROS_SVH
`define SBUS_FRAME_CHANNEL_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbus decoder check failed");

// Next-cycle implication, checked outside reset.
`define SFCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbus decoder check failed");

`endif

// ----- sv/sfcd_pkg.sv -----
`default_nettype none
package sfcd_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int RAW_W        = 11;
  localparam int VALUE_W      = 16;
  localparam int CFG_DATA_W   = 16;

  // Byte positions within a frame.
  localparam logic [4:0] POS_IDLE       = 5'd31;
  localparam logic [4:0] POS_LAST_DATA  = 5'd22;
  localparam logic [4:0] POS_FLAG       = 5'd23;
  localparam logic [4:0] POS_FRAME_LAST = 5'd24;

  localparam logic [7:0] HEADER_BYTE   = 8'h0F;
  localparam logic [7:0] FOOTER_BYTE   = 8'h00;
  localparam logic [7:0] FAILSAFE_MASK = 8'h08;
  localparam logic [7:0] LOST_MASK     = 8'h04;

  localparam logic [4:0]  WANTED_RST = 5'd16;
  localparam logic [10:0] RAW_MIN_RST = 11'd172;
  localparam logic [15:0] SCALE_RST   = 16'd10000;
  localparam logic [15:0] TARGET_RST  = 16'd1000;

  typedef enum logic [1:0] {
    CFG_CHANNELS_WANTED = 2'd0,
    CFG_RAW_MINIMUM     = 2'd1,
    CFG_SCALE_Q14       = 2'd2,
    CFG_TARGET_MINIMUM  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FRAME = 2'd1,
    ST_FAILSAFE  = 2'd2,
    ST_LOST      = 2'd3
  } frame_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic          byte_take;
    logic          load_status;
    frame_status_e status;
    logic          load_chan;
    logic [3:0]    chan_idx;
    logic          chan_last;
  } sfcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic          last_byte;
    frame_status_e verdict;
    logic [4:0]    chan_count;
    logic          out_valid;
    logic          out_taken;
  } sfcd_sts_t;

endpackage
`default_nettype wire

// ----- sv/sbus_frame_channel_decoder_core.sv -----
// Decodes one serial-bus radio frame of 25 bytes offered one byte per request, the first
// byte flagged by frame_start_i. On the final byte the frame is judged (header, footer,
// failsafe, frame lost); a bad frame, or a good one when no channels are wanted, gives
// one status request, a good one gives the first channels_wanted channels (at most
// CHANNELS), each scaled, rounded and saturated to 16 bits. Channel results leave one at
// a time: each goes through a raw store read, the single multiply stage and the offset
// and saturation stage before it reaches the output register, and the next is started
// only once the output has been taken. The input is stalled while channels are being
// produced, and the final byte of the next frame waits while the previous result is still
// unclaimed. Configuration writes are always ready and take effect on the next cycle.
`default_nettype none
module sbus_frame_channel_decoder_core
  import sfcd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            frame_byte_i,
  input  wire logic                  frame_start_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 frame_status_o,
  output logic [3:0]                 channel_index_o,
  output logic [VALUE_W-1:0]         channel_value_o,
  output logic                       value_present_o,
  output logic                       value_clipped_o,
  output logic                       last_of_frame_o
);

  sfcd_cmd_t cmd;
  sfcd_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sfcd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .frame_start_i (frame_start_i),
    .in_stall_o    (in_stall_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  sfcd_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .frame_byte_i    (frame_byte_i),
    .frame_start_i   (frame_start_i),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .frame_status_o  (frame_status_o),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .value_present_o (value_present_o),
    .value_clipped_o (value_clipped_o),
    .last_of_frame_o (last_of_frame_o),
    .out_valid_o     (out_valid_o)
  );

endmodule
`default_nettype wire

// ----- sv/sfcd_ram.sv -----
`default_nettype none
module sfcd_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- sv/sfcd_dp.sv -----
`default_nettype none
`include "sbus_frame_channel_decoder_core_macros.svh"
module sfcd_dp
  import sfcd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [7:0]            frame_byte_i,
  input  wire logic                  frame_start_i,
  input  wire logic                  out_stall_i,
  input  wire sfcd_cmd_t             cmd_i,
  output sfcd_sts_t                  sts_o,
  output logic [1:0]                 frame_status_o,
  output logic [3:0]                 channel_index_o,
  output logic [VALUE_W-1:0]         channel_value_o,
  output logic                       value_present_o,
  output logic                       value_clipped_o,
  output logic                       last_of_frame_o,
  output logic                       out_valid_o
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  logic [4:0]         wanted_q;
  logic [RAW_W-1:0]   rmin_q;
  logic [15:0]        scale_q;
  logic [15:0]        tmin_q;

  // Frame tracking and unpacking.
  logic [4:0]  pos_q, pos_d, pos_inc;
  logic        hdr_good_q, hdr_good_d;
  logic [17:0] res_q, res_d, res_or;
  logic [4:0]  cnt_q, cnt_d, cnt_sum;
  logic [4:0]  fill_q, fill_d;
  logic [7:0]  flag_q, flag_d;
  logic        ram_we;
  logic [RAW_W-1:0] raw_rd;

  // Scaling pipeline.
  logic signed [11:0] diff;
  logic signed [28:0] prod_d, prod_q;
  logic [31:0]        tsum;
  logic [VALUE_W-1:0] scaled;
  logic               clip;

  // Output register.
  logic               out_valid_q;
  logic [1:0]         ostat_q;
  logic [3:0]         oidx_q;
  logic [VALUE_W-1:0] oval_q;
  logic               opres_q, oclip_q, olast_q;
  logic               out_taken;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q <= WANTED_RST;
      rmin_q   <= RAW_MIN_RST;
      scale_q  <= SCALE_RST;
      tmin_q   <= TARGET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_CHANNELS_WANTED: wanted_q <= cfg_data_i[4:0];
        CFG_RAW_MINIMUM:     rmin_q   <= cfg_data_i[RAW_W-1:0];
        CFG_SCALE_Q14:       scale_q  <= cfg_data_i;
        CFG_TARGET_MINIMUM:  tmin_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Byte handling: start resets the frame, data bytes feed the reservoir, the flag byte is kept.
  always_comb begin
    pos_d      = pos_q;
    hdr_good_d = hdr_good_q;
    res_d      = res_q;
    cnt_d      = cnt_q;
    fill_d     = fill_q;
    flag_d     = flag_q;
    ram_we     = 1'b0;
    pos_inc    = pos_q + 5'd1;
    res_or     = res_q | (18'(frame_byte_i) << cnt_q);
    cnt_sum    = cnt_q + 5'd8;
    if (cmd_i.byte_take) begin
      if (frame_start_i) begin
        pos_d      = 5'd0;
        hdr_good_d = (frame_byte_i == HEADER_BYTE);
        res_d      = '0;
        cnt_d      = '0;
        fill_d     = '0;
        flag_d     = '0;
      end else if (pos_q < POS_FRAME_LAST) begin
        if (pos_inc <= POS_LAST_DATA) begin
          pos_d = pos_inc;
          if (cnt_sum >= 5'd11) begin
            ram_we = (fill_q < 5'(CHANNELS));
            fill_d = fill_q + 5'd1;
            res_d  = res_or >> 11;
            cnt_d  = cnt_sum - 5'd11;
          end else begin
            res_d = res_or;
            cnt_d = cnt_sum;
          end
        end else if (pos_inc == POS_FLAG) begin
          pos_d  = pos_inc;
          flag_d = frame_byte_i;
        end else begin
          pos_d = POS_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_IDLE;
      hdr_good_q <= 1'b0;
      res_q      <= '0;
      cnt_q      <= '0;
      fill_q     <= '0;
      flag_q     <= '0;
    end else begin
      pos_q      <= pos_d;
      hdr_good_q <= hdr_good_d;
      res_q      <= res_d;
      cnt_q      <= cnt_d;
      fill_q     <= fill_d;
      flag_q     <= flag_d;
    end
  end

  sfcd_ram #(
    .WIDTH (RAW_W),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_raw_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (res_or[RAW_W-1:0]),
    .raddr_i (cmd_i.chan_idx[AW-1:0]),
    .rdata_o (raw_rd)
  );

  // Scaling: one multiply stage, then offset, rounding and saturation.
  always_comb begin
    diff   = $signed({1'b0, raw_rd}) - $signed({1'b0, rmin_q});
    prod_d = diff * $signed({1'b0, scale_q});
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_comb begin
    tsum = {{3{prod_q[28]}}, prod_q} + {2'b00, tmin_q, 14'd0} + 32'd8192;
    if (tsum[31]) begin
      scaled = '0;
      clip   = 1'b1;
    end else if (tsum[30]) begin
      scaled = '1;
      clip   = 1'b1;
    end else begin
      scaled = tsum[29:14];
      clip   = 1'b0;
    end
  end

  assign out_taken = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_status || cmd_i.load_chan) begin
      out_valid_q <= 1'b1;
    end else if (out_taken) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_status) begin
      ostat_q <= cmd_i.status;
      oidx_q  <= '0;
      oval_q  <= '0;
      opres_q <= 1'b0;
      oclip_q <= 1'b0;
      olast_q <= 1'b1;
    end else if (cmd_i.load_chan) begin
      ostat_q <= ST_OK;
      oidx_q  <= cmd_i.chan_idx;
      oval_q  <= scaled;
      opres_q <= 1'b1;
      oclip_q <= clip;
      olast_q <= cmd_i.chan_last;
    end
  end

  // Frame verdict for the byte now offered as the final one.
  always_comb begin
    if (!hdr_good_q || frame_byte_i != FOOTER_BYTE) begin
      sts_o.verdict = ST_BAD_FRAME;
    end else if ((flag_q & FAILSAFE_MASK) != 8'd0) begin
      sts_o.verdict = ST_FAILSAFE;
    end else if ((flag_q & LOST_MASK) != 8'd0) begin
      sts_o.verdict = ST_LOST;
    end else begin
      sts_o.verdict = ST_OK;
    end
    sts_o.last_byte  = (pos_q == POS_FLAG);
    sts_o.chan_count = (wanted_q > 5'(CHANNELS)) ? 5'(CHANNELS) : wanted_q;
    sts_o.out_valid  = out_valid_q;
    sts_o.out_taken  = out_taken;
  end

  assign frame_status_o  = ostat_q;
  assign channel_index_o = oidx_q;
  assign channel_value_o = oval_q;
  assign value_present_o = opres_q;
  assign value_clipped_o = oclip_q;
  assign last_of_frame_o = olast_q;
  assign out_valid_o     = out_valid_q;

  `SFCD_ASSERT_IMP(a_fill_bounded, clk_i, rst_ni, 1'b1, fill_q <= 5'd16)
  `SFCD_ASSERT_IMP(a_rise_has_load, clk_i, rst_ni, $rose(out_valid_q),
                   $past(cmd_i.load_status || cmd_i.load_chan))
  `SFCD_ASSERT_NXT(a_taken_clears, clk_i, rst_ni,
                   out_taken && !cmd_i.load_status && !cmd_i.load_chan, !out_valid_q)

endmodule
`default_nettype wire

// ----- sv/sfcd_ctrl.sv -----
`default_nettype none
`include "sbus_frame_channel_decoder_core_macros.svh"
module sfcd_ctrl
  import sfcd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      frame_start_i,
  output logic           in_stall_o,
  input  wire sfcd_sts_t sts_i,
  output sfcd_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_SCALE,
    S_WAIT
  } state_e;

  state_e     state_q;
  logic [3:0] cnt_q;
  logic       take;
  logic       final_byte;
  logic       is_last;

  always_comb begin
    // The final byte needs the output register, so it waits for the taker.
    in_stall_o = (state_q != S_IDLE) || (sts_i.out_valid && sts_i.last_byte);
    take       = in_valid_i && !in_stall_o;
    final_byte = take && !frame_start_i && sts_i.last_byte;
    is_last    = ({1'b0, cnt_q} + 5'd1) == sts_i.chan_count;

    cmd_o.byte_take   = take;
    cmd_o.load_status = final_byte &&
                        (sts_i.verdict != ST_OK || sts_i.chan_count == 5'd0);
    cmd_o.status      = sts_i.verdict;
    cmd_o.load_chan   = (state_q == S_SCALE);
    cmd_o.chan_idx    = cnt_q;
    cmd_o.chan_last   = is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (final_byte && !cmd_o.load_status) begin
            cnt_q   <= '0;
            state_q <= S_READ;
          end
        end
        S_READ:  state_q <= S_MUL;
        S_MUL:   state_q <= S_SCALE;
        S_SCALE: state_q <= is_last ? S_IDLE : S_WAIT;
        S_WAIT: begin
          if (sts_i.out_taken) begin
            cnt_q   <= cnt_q + 4'd1;
            state_q <= S_READ;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `SFCD_ASSERT_IMP(a_load_into_empty, clk_i, rst_ni,
                   cmd_o.load_chan || cmd_o.load_status, !sts_i.out_valid)
  `SFCD_ASSERT_NXT(a_last_goes_idle, clk_i, rst_ni,
                   cmd_o.load_chan && cmd_o.chan_last, state_q == S_IDLE)
  `SFCD_ASSERT_IMP(a_cnt_in_range, clk_i, rst_ni, state_q != S_IDLE,
                   {1'b0, cnt_q} < sts_i.chan_count)

endmodule
`default_nettype wire
